>>> rtl/psm_pkg.sv
`default_nettype none

package psm_pkg;

  localparam int unsigned CoordW   = 13;
  localparam int unsigned CorrW    = 12;
  localparam int unsigned CorrFrac = 8;
  localparam int unsigned JumpW    = 7;
  localparam int unsigned GoalW    = 15;
  localparam int unsigned PosW     = 17;
  localparam int unsigned DistW    = 16;
  localparam int unsigned RunW     = 15;
  localparam int unsigned MoveW    = 8;
  localparam int unsigned ProdW    = CoordW + CorrW;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned DivCntW  = $clog2(DistW + 1);

  localparam int unsigned HomeMargin = 50;

  localparam logic [CoordW-1:0] ScreenWidthRst  = CoordW'(3840);
  localparam logic [CoordW-1:0] ScreenHeightRst = CoordW'(2160);
  localparam logic [CorrW-1:0]  CorrectionRst   = CorrW'(256);
  localparam logic [JumpW-1:0]  MaxJumpRst      = JumpW'(10);

  typedef enum logic [1:0] {
    MODE_SET  = 2'd0,
    MODE_STEP = 2'd1,
    MODE_HOME = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_CORRECTION    = 2'd2,
    CFG_MAX_JUMP      = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_FETCH,
    OP_MUL_X,
    OP_GOAL_X,
    OP_MUL_Y,
    OP_GOAL_Y,
    OP_DIFF,
    OP_DIV_START,
    OP_NONE,
    OP_RUN,
    OP_STEP_DIFF,
    OP_STEP_MOVE,
    OP_HOME,
    OP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_JUMP,
    BR_DISPATCH,
    BR_DIV_BUSY,
    BR_OUT_FREE
  } branch_e;

  typedef logic [AddrW-1:0] uaddr_t;

  typedef struct packed {
    uop_e    op;
    branch_e br;
    uaddr_t  target;
  } uword_t;

  typedef struct packed {
    logic  accept;
    mode_e mode;
    logic  div_busy;
    logic  out_free;
  } seq_status_t;

  localparam uaddr_t UA_FETCH = uaddr_t'(0);
  localparam uaddr_t UA_SET   = uaddr_t'(1);
  localparam uaddr_t UA_WAIT  = uaddr_t'(7);
  localparam uaddr_t UA_STEP  = uaddr_t'(9);
  localparam uaddr_t UA_HOME  = uaddr_t'(11);
  localparam uaddr_t UA_EMIT  = uaddr_t'(12);

  function automatic uword_t ucode(uaddr_t addr);
    uword_t w;
    unique case (addr)
      uaddr_t'(0):  w = '{op: OP_FETCH,     br: BR_DISPATCH, target: UA_FETCH};
      uaddr_t'(1):  w = '{op: OP_MUL_X,     br: BR_NEXT,     target: UA_FETCH};
      uaddr_t'(2):  w = '{op: OP_GOAL_X,    br: BR_NEXT,     target: UA_FETCH};
      uaddr_t'(3):  w = '{op: OP_MUL_Y,     br: BR_NEXT,     target: UA_FETCH};
      uaddr_t'(4):  w = '{op: OP_GOAL_Y,    br: BR_NEXT,     target: UA_FETCH};
      uaddr_t'(5):  w = '{op: OP_DIFF,      br: BR_NEXT,     target: UA_FETCH};
      uaddr_t'(6):  w = '{op: OP_DIV_START, br: BR_NEXT,     target: UA_FETCH};
      uaddr_t'(7):  w = '{op: OP_NONE,      br: BR_DIV_BUSY, target: UA_WAIT};
      uaddr_t'(8):  w = '{op: OP_RUN,       br: BR_JUMP,     target: UA_EMIT};
      uaddr_t'(9):  w = '{op: OP_STEP_DIFF, br: BR_NEXT,     target: UA_FETCH};
      uaddr_t'(10): w = '{op: OP_STEP_MOVE, br: BR_JUMP,     target: UA_EMIT};
      uaddr_t'(11): w = '{op: OP_HOME,      br: BR_NEXT,     target: UA_FETCH};
      uaddr_t'(12): w = '{op: OP_EMIT,      br: BR_OUT_FREE, target: UA_FETCH};
      default:      w = '{op: OP_NONE,      br: BR_JUMP,     target: UA_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/psm_div.sv
`default_nettype none

module psm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [psm_pkg::DistW-1:0]  num_i,
  input  logic [psm_pkg::DistW-1:0]  den_i,
  output logic                       busy_o,
  output logic [psm_pkg::DistW-1:0]  quot_o
);

  logic [psm_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [psm_pkg::DistW-1:0]   rem_q, rem_d;
  logic [psm_pkg::DistW-1:0]   quo_q, quo_d;
  logic [psm_pkg::DistW-1:0]   den_q, den_d;
  logic [psm_pkg::DistW:0]     shifted;
  logic [psm_pkg::DistW:0]     trial;
  logic                        fits;

  assign shifted = {rem_q, quo_q[psm_pkg::DistW-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};
  assign busy_o  = cnt_q != '0;
  assign quot_o  = quo_q;

  // one quotient bit per cycle, restoring
  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = psm_pkg::DivCntW'(psm_pkg::DistW);
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? trial[psm_pkg::DistW-1:0] : shifted[psm_pkg::DistW-1:0];
      quo_d = {quo_q[psm_pkg::DistW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

endmodule

`default_nettype wire

>>> rtl/psm_seq.sv
`default_nettype none

module psm_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psm_pkg::seq_status_t status_i,
  output psm_pkg::uword_t      uword_o
);

  psm_pkg::uaddr_t pc_q, pc_d;
  psm_pkg::uword_t uw;

  assign uw      = psm_pkg::ucode(pc_q);
  assign uword_o = uw;

  always_comb begin
    pc_d = pc_q;
    unique case (uw.br)
      psm_pkg::BR_NEXT: begin
        pc_d = pc_q + 1'b1;
      end
      psm_pkg::BR_JUMP: begin
        pc_d = uw.target;
      end
      psm_pkg::BR_DISPATCH: begin
        if (status_i.accept) begin
          unique case (status_i.mode)
            psm_pkg::MODE_SET:  pc_d = psm_pkg::UA_SET;
            psm_pkg::MODE_STEP: pc_d = psm_pkg::UA_STEP;
            psm_pkg::MODE_HOME: pc_d = psm_pkg::UA_HOME;
            psm_pkg::MODE_NONE: pc_d = psm_pkg::UA_EMIT;
          endcase
        end
      end
      psm_pkg::BR_DIV_BUSY: begin
        pc_d = status_i.div_busy ? uw.target : pc_q + 1'b1;
      end
      psm_pkg::BR_OUT_FREE: begin
        if (status_i.out_free) begin
          pc_d = uw.target;
        end
      end
      default: begin
        pc_d = psm_pkg::UA_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= psm_pkg::UA_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pointer_step_mover_core.sv
`default_nettype none

// pointer step mover: turns absolute targets into a stream of relative pointer moves
// input channel (in_valid_i / in_stall_o) takes one word per item: mode, target, home_first
// mode set target scales the target, stores it and works out the per-axis run lengths;
// mode step emits at most one clamped move; mode home clears the target, forces homing
// output channel (out_valid_o / out_stall_i) carries exactly one result word per item
// items are worked one at a time by a microcoded sequencer driving a small datapath
// set target multiplies and saturates each axis, takes the differences, then waits on the
// two 16-bit restoring dividers running side by side; step works out the offset, then
// moves; home clears the goal; the unused mode goes straight to the emit step
// the next word is fetched as the result appears
// the result sits in an output register, so a new word is taken while it waits;
// when out_stall_i is high the result holds, and a next item waits at its emit step
// configuration (cfg_we_i, cfg_idx_i, cfg_data_i) writes at once; the user writes it only
// while idle and the block does not enforce it; reset loads the default configuration,
// clears position, target and homing state and sets both run lengths to one

module pointer_step_mover_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [psm_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [psm_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          mode_i,
  input  logic [psm_pkg::CoordW-1:0]          target_x_i,
  input  logic [psm_pkg::CoordW-1:0]          target_y_i,
  input  logic                                home_first_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                report_valid_o,
  output logic signed [psm_pkg::MoveW-1:0]    move_dx_o,
  output logic signed [psm_pkg::MoveW-1:0]    move_dy_o,
  output logic                                arrived_o
);

  localparam int unsigned PosW  = psm_pkg::PosW;
  localparam int unsigned GoalW = psm_pkg::GoalW;
  localparam int unsigned DistW = psm_pkg::DistW;
  localparam int unsigned RunW  = psm_pkg::RunW;
  localparam int unsigned MoveW = psm_pkg::MoveW;
  localparam int unsigned ProdW = psm_pkg::ProdW;
  localparam int unsigned JumpW = psm_pkg::JumpW;
  localparam int unsigned SclW  = ProdW - psm_pkg::CorrFrac;

  function automatic logic [GoalW-1:0] goal_sat(logic [ProdW-1:0] p);
    logic [SclW-1:0] s;
    s = p[ProdW-1:psm_pkg::CorrFrac];
    return (s[SclW-1:GoalW] != '0) ? '1 : s[GoalW-1:0];
  endfunction

  function automatic logic [DistW-1:0] mag(logic signed [PosW-1:0] v);
    logic signed [PosW-1:0] n;
    n = (v < 0) ? -v : v;
    return n[DistW-1:0];
  endfunction

  function automatic logic [RunW-1:0] run_sat(logic den_zero, logic [DistW-1:0] q);
    logic [RunW-1:0] r;
    if (den_zero || q == '0) begin
      r = RunW'(1);
    end else if (q[DistW-1:RunW] != '0) begin
      r = '1;
    end else begin
      r = q[RunW-1:0];
    end
    return r;
  endfunction

  function automatic logic [MoveW-1:0] clamp(logic signed [PosW-1:0] d,
                                             logic [JumpW-1:0] j);
    logic signed [PosW-1:0] js;
    logic signed [PosW-1:0] r;
    js = $signed(PosW'(j));
    if (d > js) begin
      r = js;
    end else if (d < -js) begin
      r = -js;
    end else begin
      r = d;
    end
    return r[MoveW-1:0];
  endfunction

  psm_pkg::uword_t      uw;
  psm_pkg::seq_status_t st;

  logic accept;
  logic out_free;
  logic busy_x, busy_y;
  logic [DistW-1:0] quot_x, quot_y;

  // configuration
  logic [psm_pkg::CoordW-1:0] sw_q, sw_d, sh_q, sh_d;
  logic [psm_pkg::CorrW-1:0]  corr_q, corr_d;
  logic [JumpW-1:0]           jump_q, jump_d;

  // architectural state
  logic [GoalW-1:0]       goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic signed [PosW-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic                   homed_q, homed_d, on_x_q, on_x_d;
  logic [RunW-1:0]        run_x_q, run_x_d, run_y_q, run_y_d;
  logic [RunW-1:0]        left_x_q, left_x_d, left_y_q, left_y_d;
  logic                   out_valid_q, out_valid_d;

  // working registers
  logic [psm_pkg::CoordW-1:0] tx_q, tx_d, ty_q, ty_d;
  logic                       hf_q, hf_d;
  logic [ProdW-1:0]           prod_q, prod_d;
  logic [DistW-1:0]           ax_q, ax_d, ay_q, ay_d;
  logic signed [PosW-1:0]     dxd_q, dxd_d, dyd_q, dyd_d;
  logic                       res_valid_q, res_valid_d, res_arr_q, res_arr_d;
  logic [MoveW-1:0]           res_dx_q, res_dx_d, res_dy_q, res_dy_d;
  logic                       rep_q, rep_d, arr_q, arr_d;
  logic [MoveW-1:0]           dx_q, dx_d, dy_q, dy_d;

  // datapath terms
  logic signed [PosW-1:0] gx_s, gy_s, home_x, home_y;
  logic signed [PosW-1:0] mx_ext, my_ext;
  logic [MoveW-1:0]       mx, my;
  logic [RunW-1:0]        left_x_dec, left_y_dec;
  logic                   x_ne, y_ne;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = uw.op != psm_pkg::OP_FETCH;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign st = '{accept:   accept,
                mode:     psm_pkg::mode_e'(mode_i),
                div_busy: busy_x || busy_y,
                out_free: out_free};

  psm_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (st),
    .uword_o  (uw)
  );

  psm_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (uw.op == psm_pkg::OP_DIV_START),
    .num_i   (ax_q),
    .den_i   (ay_q),
    .busy_o  (busy_x),
    .quot_o  (quot_x)
  );

  psm_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (uw.op == psm_pkg::OP_DIV_START),
    .num_i   (ay_q),
    .den_i   (ax_q),
    .busy_o  (busy_y),
    .quot_o  (quot_y)
  );

  assign gx_s   = $signed({{(PosW-GoalW){1'b0}}, goal_x_q});
  assign gy_s   = $signed({{(PosW-GoalW){1'b0}}, goal_y_q});
  assign home_x = -$signed(PosW'(sw_q) + PosW'(psm_pkg::HomeMargin));
  assign home_y = -$signed(PosW'(sh_q) + PosW'(psm_pkg::HomeMargin));

  assign mx     = clamp(dxd_q, jump_q);
  assign my     = clamp(dyd_q, jump_q);
  assign mx_ext = $signed({{(PosW-MoveW){mx[MoveW-1]}}, mx});
  assign my_ext = $signed({{(PosW-MoveW){my[MoveW-1]}}, my});
  assign x_ne   = dxd_q != '0;
  assign y_ne   = dyd_q != '0;

  assign left_x_dec = left_x_q - RunW'(left_x_q != '0);
  assign left_y_dec = left_y_q - RunW'(left_y_q != '0);

  always_comb begin
    sw_d        = sw_q;
    sh_d        = sh_q;
    corr_d      = corr_q;
    jump_d      = jump_q;
    goal_x_d    = goal_x_q;
    goal_y_d    = goal_y_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    homed_d     = homed_q;
    on_x_d      = on_x_q;
    run_x_d     = run_x_q;
    run_y_d     = run_y_q;
    left_x_d    = left_x_q;
    left_y_d    = left_y_q;
    out_valid_d = out_valid_q && out_stall_i;
    tx_d        = tx_q;
    ty_d        = ty_q;
    hf_d        = hf_q;
    prod_d      = prod_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    dxd_d       = dxd_q;
    dyd_d       = dyd_q;
    res_valid_d = res_valid_q;
    res_arr_d   = res_arr_q;
    res_dx_d    = res_dx_q;
    res_dy_d    = res_dy_q;
    rep_d       = rep_q;
    arr_d       = arr_q;
    dx_d        = dx_q;
    dy_d        = dy_q;

    if (cfg_we_i) begin
      unique case (psm_pkg::cfg_idx_e'(cfg_idx_i))
        psm_pkg::CFG_SCREEN_WIDTH:  sw_d   = cfg_data_i;
        psm_pkg::CFG_SCREEN_HEIGHT: sh_d   = cfg_data_i;
        psm_pkg::CFG_CORRECTION:    corr_d = cfg_data_i[psm_pkg::CorrW-1:0];
        psm_pkg::CFG_MAX_JUMP:      jump_d = cfg_data_i[JumpW-1:0];
      endcase
    end

    unique case (uw.op)
      psm_pkg::OP_FETCH: begin
        if (accept) begin
          tx_d        = target_x_i;
          ty_d        = target_y_i;
          hf_d        = home_first_i;
          res_valid_d = 1'b0;
          res_arr_d   = 1'b0;
          res_dx_d    = '0;
          res_dy_d    = '0;
        end
      end
      psm_pkg::OP_MUL_X: begin
        prod_d = ProdW'(tx_q) * ProdW'(corr_q);
      end
      psm_pkg::OP_GOAL_X: begin
        goal_x_d = goal_sat(prod_q);
      end
      psm_pkg::OP_MUL_Y: begin
        prod_d = ProdW'(ty_q) * ProdW'(corr_q);
      end
      psm_pkg::OP_GOAL_Y: begin
        goal_y_d = goal_sat(prod_q);
      end
      psm_pkg::OP_DIFF: begin
        homed_d = !hf_q;
        ax_d    = mag(hf_q ? gx_s : gx_s - pos_x_q);
        ay_d    = mag(hf_q ? gy_s : gy_s - pos_y_q);
      end
      psm_pkg::OP_RUN: begin
        run_x_d  = run_sat(ay_q == '0, quot_x);
        run_y_d  = run_sat(ax_q == '0, quot_y);
        left_x_d = run_sat(ay_q == '0, quot_x);
        left_y_d = run_sat(ax_q == '0, quot_y);
      end
      psm_pkg::OP_STEP_DIFF: begin
        dxd_d = (homed_q ? gx_s : home_x) - pos_x_q;
        dyd_d = (homed_q ? gy_s : home_y) - pos_y_q;
      end
      psm_pkg::OP_STEP_MOVE: begin
        if (x_ne || y_ne) begin
          res_valid_d = 1'b1;
          if (x_ne && (!y_ne || on_x_q)) begin
            res_dx_d = mx;
            pos_x_d  = pos_x_q + mx_ext;
            if (left_x_dec == '0) begin
              on_x_d   = 1'b0;
              left_x_d = run_x_q;
            end else begin
              left_x_d = left_x_dec;
            end
          end else begin
            res_dy_d = -my;
            pos_y_d  = pos_y_q + my_ext;
            if (left_y_dec == '0) begin
              on_x_d   = 1'b1;
              left_y_d = run_y_q;
            end else begin
              left_y_d = left_y_dec;
            end
          end
        end else if (!homed_q) begin
          homed_d = 1'b1;
          pos_x_d = '0;
          pos_y_d = '0;
        end else begin
          homed_d   = 1'b0;
          run_x_d   = RunW'(1);
          run_y_d   = RunW'(1);
          left_x_d  = RunW'(1);
          left_y_d  = RunW'(1);
          res_arr_d = 1'b1;
        end
      end
      psm_pkg::OP_HOME: begin
        homed_d  = 1'b0;
        goal_x_d = '0;
        goal_y_d = '0;
      end
      psm_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rep_d       = res_valid_q;
          arr_d       = res_arr_q;
          dx_d        = res_dx_q;
          dy_d        = res_dy_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q        <= psm_pkg::ScreenWidthRst;
      sh_q        <= psm_pkg::ScreenHeightRst;
      corr_q      <= psm_pkg::CorrectionRst;
      jump_q      <= psm_pkg::MaxJumpRst;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      homed_q     <= 1'b0;
      on_x_q      <= 1'b0;
      run_x_q     <= RunW'(1);
      run_y_q     <= RunW'(1);
      left_x_q    <= '0;
      left_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sw_q        <= sw_d;
      sh_q        <= sh_d;
      corr_q      <= corr_d;
      jump_q      <= jump_d;
      goal_x_q    <= goal_x_d;
      goal_y_q    <= goal_y_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      homed_q     <= homed_d;
      on_x_q      <= on_x_d;
      run_x_q     <= run_x_d;
      run_y_q     <= run_y_d;
      left_x_q    <= left_x_d;
      left_y_q    <= left_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_q        <= tx_d;
    ty_q        <= ty_d;
    hf_q        <= hf_d;
    prod_q      <= prod_d;
    ax_q        <= ax_d;
    ay_q        <= ay_d;
    dxd_q       <= dxd_d;
    dyd_q       <= dyd_d;
    res_valid_q <= res_valid_d;
    res_arr_q   <= res_arr_d;
    res_dx_q    <= res_dx_d;
    res_dy_q    <= res_dy_d;
    rep_q       <= rep_d;
    arr_q       <= arr_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
  end

  assign out_valid_o    = out_valid_q;
  assign report_valid_o = rep_q;
  assign arrived_o      = arr_q;
  assign move_dx_o      = $signed(dx_q);
  assign move_dy_o      = $signed(dy_q);

endmodule

`default_nettype wire

>>> rtl/psm_checker.sv
`default_nettype none

module psm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             report_valid_o,
  input logic signed [psm_pkg::MoveW-1:0] move_dx_o,
  input logic signed [psm_pkg::MoveW-1:0] move_dy_o,
  input logic                             arrived_o
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(report_valid_o) && $stable(move_dx_o)
      && $stable(move_dy_o) && $stable(arrived_o))
    else $error("result word changed while stalled");

  // one item in flight: an accepted word closes the input for the next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while an item is in work");

  // no move without report, arrival carries no move
  a_quiet_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (!report_valid_o || arrived_o) |->
      move_dx_o == '0 && move_dy_o == '0 && !(report_valid_o && arrived_o))
    else $error("move on a non-move result");

  // a move is on one axis only
  a_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> move_dx_o == '0 || move_dy_o == '0)
    else $error("move on both axes");

endmodule

bind pointer_step_mover_core psm_checker u_psm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .report_valid_o (report_valid_o),
  .move_dx_o      (move_dx_o),
  .move_dy_o      (move_dy_o),
  .arrived_o      (arrived_o)
);

`default_nettype wire
